### rtl/core/badc_pkg.sv
// ----------------------------------------------------------------------------
// badc_pkg: shared types and constants for the block average distance converter
// Item structs, lane status, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package badc_pkg;

    localparam int NUM_CH                  = 4;
    localparam int SAMPLE_W                = 10;
    localparam int DIST_W                  = 16;
    localparam int CFG_W                   = 16;
    localparam int CFG_IDX_W               = 4;
    localparam int SAMPLES_PER_AVERAGE_DEF = 10;

    // Average is at most 1023, so it keeps the sample width
    localparam int AVG_W     = SAMPLE_W;
    // Denominator in hundredths: 1023 * 100 + 65535 fits in 18 bits
    localparam int DEN_W     = 18;
    // Numerator: 65535 * 100 * 64 fits in 29 bits
    localparam int NUM_W     = 29;
    localparam int Q6_FRAC_W = 6;

    localparam logic [6:0]        HUNDRED  = 7'd100;
    localparam logic [NUM_W-1:0]  Q6_ONE   = NUM_W'(64);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [CFG_W-1:0] SCALE_RESET  = 16'd2914;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 16'd498;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_NUMERATOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_HUNDREDTHS = CFG_IDX_W'(1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_ch0;
        logic [SAMPLE_W-1:0] sample_ch1;
        logic [SAMPLE_W-1:0] sample_ch2;
        logic [SAMPLE_W-1:0] sample_ch3;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_ch0;
        logic [DIST_W-1:0] distance_ch1;
        logic [DIST_W-1:0] distance_ch2;
        logic [DIST_W-1:0] distance_ch3;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_status_t;

endpackage

### rtl/core/badc_div.sv
// ----------------------------------------------------------------------------
// badc_div: restoring divider, one quotient bit per cycle
// Unsigned division; a zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module badc_div #(
    parameter int DVD_W = 29,
    parameter int DSR_W = 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W:0]   rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;

    logic [DSR_W:0] shifted;
    logic [DSR_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg[DSR_W-1:0], quo_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, keep the quotient bit at the bottom
            rem_next = ge ? diff : shifted;
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/badc_lane.sv
// ----------------------------------------------------------------------------
// badc_lane: one channel of accumulation, averaging and range conversion
// Keeps the running sum; on the last item of a block it takes the average by
// a reciprocal multiplication and then divides the scaled numerator by the
// offset average.
// ----------------------------------------------------------------------------
module badc_lane #(
    parameter int SAMPLES_PER_AVERAGE = badc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           last,
    input  logic [badc_pkg::SAMPLE_W-1:0]  sample,
    input  logic [badc_pkg::CFG_W-1:0]     scale,
    input  logic [badc_pkg::CFG_W-1:0]     offset,
    output badc_pkg::lane_status_t         status,
    output logic [badc_pkg::DIST_W-1:0]    distance
);

    import badc_pkg::*;

    localparam int SUM_W   = $clog2(SAMPLES_PER_AVERAGE * 1023 + 1);
    // Reciprocal of the block length, exact for every sum below 2**SUM_W
    localparam int SHIFT_W = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RCP_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((1 << SHIFT_W) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_AVG,
        S_START,
        S_CONV
    } lane_state_t;

    lane_state_t       state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              done_reg, done_next;

    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_quotient;

    logic [SUM_W-1:0]  sum_in;
    logic [PROD_W-1:0] avg_prod;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  quo;
    logic [NUM_W-1:0]  dist_wide;

    assign sum_in   = sum_reg + SUM_W'(sample);
    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RCP);
    assign den      = DEN_W'(avg_reg) * DEN_W'(HUNDRED) + DEN_W'(offset);
    assign num      = (NUM_W'(scale) * NUM_W'(HUNDRED)) << Q6_FRAC_W;
    assign quo      = div_quotient;

    // A zero denominator leaves an all-ones quotient, which saturates below
    assign dist_wide = quo - Q6_ONE;

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        avg_next   = avg_reg;
        dist_next  = dist_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sum_next = sum_in;
                    if (last)
                        state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                avg_next   = avg_prod[SHIFT_W +: AVG_W];
                sum_next   = '0;
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_CONV;
            end
            S_CONV:
            begin
                if (div_done)
                begin
                    if (quo < Q6_ONE)
                        dist_next = '0;
                    else if (dist_wide > NUM_W'(DIST_MAX))
                        dist_next = DIST_MAX;
                    else
                        dist_next = dist_wide[DIST_W-1:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            avg_reg   <= '0;
            done_reg  <= 1'b0;
            dist_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            avg_reg   <= avg_next;
            done_reg  <= done_next;
            dist_reg  <= dist_next;
        end
    end

    badc_div #(
        .DVD_W (NUM_W),
        .DSR_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num),
        .divisor  (den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign status   = '{busy: (state_reg != S_IDLE) || div_busy, done: done_reg};
    assign distance = dist_reg;

endmodule

### rtl/core/block_average_distance_converter_unit.sv
// ----------------------------------------------------------------------------
// block_average_distance_converter_unit: four-channel boxcar average to range
// Averages blocks of ADC items per channel and converts each average to a
// saturated Q10.6 distance in centimetres.
// ----------------------------------------------------------------------------
// An item that does not close a block gives no result. The item that closes a
// block starts four lanes, one per channel: each takes its average by a
// reciprocal multiplication, then runs a restoring divider that produces the
// 29-bit quotient one bit a cycle, and the input stalls while the lanes are
// busy. A closing item also stalls while the previous result has not been
// taken. The configuration port is always ready; write it only while the
// block is idle.
module block_average_distance_converter_unit #(
    parameter int SAMPLES_PER_AVERAGE = badc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  badc_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output badc_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [badc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [badc_pkg::CFG_W-1:0]      cfg_data
);

    import badc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);

    logic [CFG_W-1:0] scale_reg, scale_next;
    logic [CFG_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic [SAMPLE_W-1:0] samples [NUM_CH];
    logic [DIST_W-1:0]   dists   [NUM_CH];
    lane_status_t        lane_status [NUM_CH];
    logic [NUM_CH-1:0]   lane_busy;
    logic [NUM_CH-1:0]   lane_done;

    logic in_accept;
    logic last;
    logic lanes_busy;
    logic lanes_done;

    assign samples[0] = in_data.sample_ch0;
    assign samples[1] = in_data.sample_ch1;
    assign samples[2] = in_data.sample_ch2;
    assign samples[3] = in_data.sample_ch3;

    assign last       = count_reg == CNT_W'(SAMPLES_PER_AVERAGE - 1);
    assign lanes_busy = |lane_busy;
    assign lanes_done = &lane_done;

    // Hold every item back while the lanes are busy, and a closing item until the result slot is free
    assign in_stall  = lanes_busy || ((out_valid_reg || lanes_done) && last);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        badc_lane #(
            .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .accept   (in_accept),
            .last     (last),
            .sample   (samples[ch]),
            .scale    (scale_reg),
            .offset   (offset_reg),
            .status   (lane_status[ch]),
            .distance (dists[ch])
        );
        assign lane_busy[ch] = lane_status[ch].busy;
        assign lane_done[ch] = lane_status[ch].done;
    end

    always_comb
    begin
        scale_next     = scale_reg;
        offset_next    = offset_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE_NUMERATOR:   scale_next  = cfg_data;
                CFG_OFFSET_HUNDREDTHS: offset_next = cfg_data;
                default:               ;
            endcase
        end

        if (in_accept)
            count_next = last ? '0 : count_reg + CNT_W'(1);

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // Merge the four lanes into one result item
        if (lanes_done)
        begin
            out_valid_next              = 1'b1;
            out_data_next.distance_ch0  = dists[0];
            out_data_next.distance_ch1  = dists[1];
            out_data_next.distance_ch2  = dists[2];
            out_data_next.distance_ch3  = dists[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RESET;
            offset_reg    <= OFFSET_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scale_reg     <= scale_next;
            offset_reg    <= offset_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> lanes_done)
        else $error("lanes finished out of step");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        lanes_busy |-> in_stall)
        else $error("item accepted while lanes busy");

    a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last) |=> lanes_busy)
        else $error("closing item did not start the lanes");

    a_result_from_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(lanes_done))
        else $error("result raised without lane completion");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        lanes_done |-> !out_valid_reg)
        else $error("lane result would overwrite a pending item");
`endif

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for block_average_distance_converter_unit
// Drives blocks of four-channel ADC items through the valid/stall input,
// predicts each block's averaged Q10.6 distances and checks every result
// against the oldest prediction. Covers extremes, register settings,
// random idling on both sides and long back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import badc_pkg::*;

    localparam int BLOCK_LEN          = SAMPLES_PER_AVERAGE_DEF;
    localparam int SETTLE_CYCLES      = 100;
    localparam int LIMIT_CYCLES       = 300000;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int FIRST_UNUSED_INDEX = CFG_OFFSET_HUNDREDTHS + 1;
    localparam int LAST_UNUSED_INDEX  = (1 << CFG_IDX_W) - 1;

    typedef enum int {LEVEL_ZERO, LEVEL_LOW, LEVEL_HIGH, LEVEL_ANY} level_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predictor state
    logic [CFG_W-1:0] scale_reg  = SCALE_RESET;
    logic [CFG_W-1:0] offset_reg = OFFSET_RESET;
    int unsigned      channel_total [NUM_CH] = '{default: 0};
    int unsigned      block_fill = 0;
    out_item_t        pending_distances [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle     = 1'b0;
    bit  rx_idle     = 1'b0;
    int  rx_hold     = 0;
    int  rx_gap      = 0;
    bit  rx_armed    = 1'b0;

    block_average_distance_converter_unit #(
        .SAMPLES_PER_AVERAGE (BLOCK_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic flag_mismatch(string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic logic [DIST_W-1:0] range_from_average(int unsigned avg);
        longint unsigned den;
        longint unsigned quot;
        den = longint'(avg) * HUNDRED + offset_reg;
        // a zero denominator overflows the divider
        if (den == 0)
            return DIST_MAX;
        quot = (longint'(scale_reg) * HUNDRED * Q6_ONE) / den;
        if (quot < Q6_ONE)
            return '0;
        quot -= Q6_ONE;
        if (quot > DIST_MAX)
            return DIST_MAX;
        return quot[DIST_W-1:0];
    endfunction

    task automatic accumulate_item(in_item_t item);
        logic [DIST_W-1:0] ch_dist [NUM_CH];
        out_item_t         res;
        channel_total[0] += item.sample_ch0;
        channel_total[1] += item.sample_ch1;
        channel_total[2] += item.sample_ch2;
        channel_total[3] += item.sample_ch3;
        block_fill++;
        if (block_fill == BLOCK_LEN)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                ch_dist[ch] = range_from_average(channel_total[ch] / BLOCK_LEN);
                channel_total[ch] = 0;
            end
            res.distance_ch0 = ch_dist[0];
            res.distance_ch1 = ch_dist[1];
            res.distance_ch2 = ch_dist[2];
            res.distance_ch3 = ch_dist[3];
            pending_distances.push_back(res);
            block_fill = 0;
        end
    endtask

    // Starts at a falling edge, returns at the rising edge that took the item
    task automatic send_item(in_item_t item);
        int gap;
        @(negedge clk);
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        accumulate_item(item);
    endtask

    task automatic send_samples(logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1,
                                logic [SAMPLE_W-1:0] s2, logic [SAMPLE_W-1:0] s3);
        in_item_t item;
        item.sample_ch0 = s0;
        item.sample_ch1 = s1;
        item.sample_ch2 = s2;
        item.sample_ch3 = s3;
        send_item(item);
    endtask

    // Drop valid, wait for every expected result, then hold the input idle to settle
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SCALE_NUMERATOR:   scale_reg  = value;
            CFG_OFFSET_HUNDREDTHS: offset_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(level_t lvl);
        case (lvl)
            LEVEL_ZERO: return '0;
            LEVEL_LOW:  return SAMPLE_W'($urandom_range(0, 3));
            LEVEL_HIGH: return ($urandom_range(0, 3) == 0) ? SAMPLE_W'(1022) : '1;
            default:    return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
        endcase
    endfunction

    // Random items; each channel keeps one level until its block closes or a new call starts
    task automatic send_random_items(int count);
        level_t lvl [NUM_CH];
        for (int n = 0; n < count; n++)
        begin
            if (block_fill == 0 || n == 0)
                for (int ch = 0; ch < NUM_CH; ch++)
                    lvl[ch] = ($urandom_range(0, 1) == 0) ? LEVEL_ANY
                              : level_t'($urandom_range(LEVEL_ZERO, LEVEL_ANY));
            send_samples(pick_sample(lvl[0]), pick_sample(lvl[1]),
                         pick_sample(lvl[2]), pick_sample(lvl[3]));
        end
    endtask

    // Receiver: an optional long hold-off first, then a random per-result stall when rx_idle is set
    always @(negedge clk)
    begin
        if (out_valid && !rx_armed)
        begin
            rx_armed = 1'b1;
            rx_gap   = rx_idle ? $urandom_range(0, 7) : 0;
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(string name, logic [DIST_W-1:0] got,
                               logic [DIST_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            rx_armed = 1'b0;
            if (pending_distances.size() == 0)
                flag_mismatch($sformatf("unexpected result %h", out_data));
            else
            begin
                want = pending_distances.pop_front();
                check_field("distance_ch0", out_data.distance_ch0, want.distance_ch0);
                check_field("distance_ch1", out_data.distance_ch1, want.distance_ch1);
                check_field("distance_ch2", out_data.distance_ch2, want.distance_ch2);
                check_field("distance_ch3", out_data.distance_ch3, want.distance_ch3);
            end
        end
    end

    task automatic test_directed_extremes();
        // reset settings: flat zero, full scale, alternating bits (floored average), ramp
        for (int i = 0; i < BLOCK_LEN; i++)
            send_samples('0, '1, i[0] ? 10'h2AA : 10'h155, SAMPLE_W'(i * 100 + 7));
        settle_idle();
        // zero offset: zero denominator and overflow past the maximum
        write_reg(CFG_SCALE_NUMERATOR, '1);
        write_reg(CFG_OFFSET_HUNDREDTHS, '0);
        for (int i = 0; i < BLOCK_LEN; i++)
            send_samples('0, (i == 0) ? SAMPLE_W'(BLOCK_LEN) : '0, '1, SAMPLE_W'(9));
        settle_idle();
        // unused register index is ignored; zero numerator saturates at zero
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_UNUSED_INDEX)),
                  CFG_W'($urandom));
        write_reg(CFG_SCALE_NUMERATOR, '0);
        send_random_items(BLOCK_LEN);
        settle_idle();
    endtask

    task automatic test_config_sweep();
        logic [CFG_W-1:0] scale_set  [6];
        logic [CFG_W-1:0] offset_set [6];
        scale_set  = '{16'd1, '1, '1, '0, CFG_W'($urandom), SCALE_RESET};
        offset_set = '{'0, '1, '0, CFG_W'($urandom), CFG_W'($urandom), OFFSET_RESET};
        for (int k = 0; k < 6; k++)
        begin
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_SCALE_NUMERATOR, scale_set[k]);
                write_reg(CFG_OFFSET_HUNDREDTHS, offset_set[k]);
            end
            else
            begin
                write_reg(CFG_OFFSET_HUNDREDTHS, offset_set[k]);
                write_reg(CFG_SCALE_NUMERATOR, scale_set[k]);
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_UNUSED_INDEX)),
                          CFG_W'($urandom));
            tx_idle = (k % 4 == 0) || (k % 4 == 1);
            rx_idle = (k % 4 == 0) || (k % 4 == 2);
            send_random_items($urandom_range(120, 140));
            settle_idle();
        end
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        // hold the receiver off so the pipeline fills and stalls its input
        @(posedge clk);
        rx_hold = HOLD_OFF_CYCLES;
        send_random_items(4 * BLOCK_LEN);
        // pause the sender until every result is back, then resume
        settle_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random_items(BLOCK_LEN + 3);
        settle_idle();
        send_random_items(2 * BLOCK_LEN - 3);
        settle_idle();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_extremes();
        test_config_sweep();
        test_backpressure();
        settle_idle();
        if (pending_distances.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_distances.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
